[hdl/lsbsd_pkg.sv]
// Shared types and codes for the LSB steganography stream decoder.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lsbsd_pkg;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_EXTCHR  = 3'd3;
  localparam logic [2:0] PH_PAYLEN  = 3'd4;
  localparam logic [2:0] PH_PAYBYTE = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [2:0] KIND_EXTLEN   = 3'd0;
  localparam logic [2:0] KIND_EXTCHR   = 3'd1;
  localparam logic [2:0] KIND_PAYLEN   = 3'd2;
  localparam logic [2:0] KIND_PAYBYTE  = 3'd3;
  localparam logic [2:0] KIND_MISMATCH = 3'd4;

  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_HEADER_SKIP  = 2'd2;

  localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'd42;
  localparam logic [7:0] HEADER_SKIP_RST  = 8'd54;

  localparam logic [7:0] CHAR_BITS = 8'd8;
  localparam logic [7:0] SIZE_BITS = 8'd32;

  typedef struct packed {
    logic       valid;
    logic [7:0] image_byte;
    logic       start_req;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  out_kind;
    logic [31:0] out_value;
    logic        final_res;
  } result_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] header_skip;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/lsbsd_in_stage.sv]
// Input register for image bytes.
// Depends on lsbsd_pkg for the item type.
`default_nettype none

module lsbsd_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_valid,
  output      logic           s_ready,
  input  wire logic [7:0]     s_data,
  input  wire logic           s_start,
  input  wire logic           consume,
  output      lsbsd_pkg::item_t item
);

  assign s_ready = !item.valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_ready) begin
      item.valid <= s_valid;
    end
    if (s_ready) begin
      item.image_byte <= s_data;
      item.start_req  <= s_start;
    end
  end

endmodule

`default_nettype wire

[hdl/lsbsd_decode.sv]
// Decode state and next-state logic: header skip, bit gathering, field sequencing.
// Depends on lsbsd_pkg for phase and kind codes and shared types.
`default_nettype none

module lsbsd_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire lsbsd_pkg::item_t  item,
  input  wire lsbsd_pkg::cfg_t   cfg,
  output      lsbsd_pkg::result_t res
);

  logic [2:0]  phase,       phase_next;
  logic [31:0] bit_gather,  bit_gather_next;
  logic [7:0]  bit_count,   bit_count_next;
  logic [31:0] remaining,   remaining_next;
  logic        magic_index, magic_index_next;
  logic        magic_ok,    magic_ok_next;

  always_comb begin
    logic        go;
    logic        need32;
    logic        full;
    logic [31:0] v;
    logic [7:0]  expect_chr;
    phase_next       = phase;
    bit_gather_next  = bit_gather;
    bit_count_next   = bit_count;
    remaining_next   = remaining;
    magic_index_next = magic_index;
    magic_ok_next    = magic_ok;
    res              = '0;
    go               = 1'b0;
    need32           = 1'b0;
    full             = 1'b0;
    v                = '0;
    expect_chr       = '0;

    if (item.start_req) begin
      phase_next       = lsbsd_pkg::PH_HEADER;
      bit_gather_next  = '0;
      bit_count_next   = '0;
      remaining_next   = '0;
      magic_index_next = 1'b0;
      magic_ok_next    = 1'b1;
    end

    if (phase_next != lsbsd_pkg::PH_DONE) begin
      go = 1'b1;
      if (phase_next == lsbsd_pkg::PH_HEADER) begin
        if (bit_count_next < cfg.header_skip) begin
          bit_count_next = bit_count_next + 8'd1;
          go = 1'b0;
        end else begin
          phase_next      = lsbsd_pkg::PH_MAGIC;
          bit_count_next  = '0;
          bit_gather_next = '0;
        end
      end
    end

    if (go) begin
      bit_gather_next = {bit_gather_next[30:0], item.image_byte[0]};
      bit_count_next  = bit_count_next + 8'd1;
      need32 = (phase_next == lsbsd_pkg::PH_EXTLEN) || (phase_next == lsbsd_pkg::PH_PAYLEN);
      full   = need32 ? (bit_count_next == lsbsd_pkg::SIZE_BITS)
                      : (bit_count_next == lsbsd_pkg::CHAR_BITS);
      v      = need32 ? bit_gather_next : {24'd0, bit_gather_next[7:0]};
      if (full) begin
        bit_gather_next = '0;
        bit_count_next  = '0;
        case (phase_next)
          lsbsd_pkg::PH_MAGIC: begin
            expect_chr = magic_index_next ? cfg.magic_second : cfg.magic_first;
            if (v[7:0] != expect_chr) magic_ok_next = 1'b0;
            if (!magic_index_next) begin
              magic_index_next = 1'b1;
            end else begin
              magic_index_next = 1'b0;
              if (!magic_ok_next) begin
                phase_next = lsbsd_pkg::PH_DONE;
                res = '{valid: 1'b1, out_kind: lsbsd_pkg::KIND_MISMATCH,
                        out_value: 32'd0, final_res: 1'b1};
              end else begin
                phase_next = lsbsd_pkg::PH_EXTLEN;
              end
            end
          end
          lsbsd_pkg::PH_EXTLEN: begin
            remaining_next = v;
            phase_next = (v == 32'd0) ? lsbsd_pkg::PH_PAYLEN : lsbsd_pkg::PH_EXTCHR;
            res = '{valid: 1'b1, out_kind: lsbsd_pkg::KIND_EXTLEN,
                    out_value: v, final_res: 1'b0};
          end
          lsbsd_pkg::PH_EXTCHR: begin
            remaining_next = remaining_next - 32'd1;
            if (remaining_next == 32'd0) phase_next = lsbsd_pkg::PH_PAYLEN;
            res = '{valid: 1'b1, out_kind: lsbsd_pkg::KIND_EXTCHR,
                    out_value: v, final_res: 1'b0};
          end
          lsbsd_pkg::PH_PAYLEN: begin
            remaining_next = v;
            phase_next = (v == 32'd0) ? lsbsd_pkg::PH_DONE : lsbsd_pkg::PH_PAYBYTE;
            res = '{valid: 1'b1, out_kind: lsbsd_pkg::KIND_PAYLEN,
                    out_value: v, final_res: (v == 32'd0)};
          end
          lsbsd_pkg::PH_PAYBYTE: begin
            remaining_next = remaining_next - 32'd1;
            if (remaining_next == 32'd0) phase_next = lsbsd_pkg::PH_DONE;
            res = '{valid: 1'b1, out_kind: lsbsd_pkg::KIND_PAYBYTE,
                    out_value: v, final_res: (remaining_next == 32'd0)};
          end
          default: begin
            phase_next = lsbsd_pkg::PH_DONE;
          end
        endcase
      end
    end

    res.valid = res.valid && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lsbsd_pkg::PH_HEADER;
      bit_gather  <= '0;
      bit_count   <= '0;
      remaining   <= '0;
      magic_index <= 1'b0;
      magic_ok    <= 1'b1;
    end else if (step) begin
      phase       <= phase_next;
      bit_gather  <= bit_gather_next;
      bit_count   <= bit_count_next;
      remaining   <= remaining_next;
      magic_index <= magic_index_next;
      magic_ok    <= magic_ok_next;
    end
  end

endmodule

`default_nettype wire

[hdl/lsbsd_out_stage.sv]
// Result register feeding the master-side stream.
// Depends on lsbsd_pkg for the result type.
`default_nettype none

module lsbsd_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lsbsd_pkg::result_t res,
  output      logic               load_ok,
  output      logic               m_valid,
  input  wire logic               m_ready,
  output      logic [31:0]        m_data,
  output      logic [2:0]         m_kind,
  output      logic               m_last
);

  assign load_ok = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_ok) begin
      m_valid <= res.valid;
    end
    if (load_ok) begin
      m_data <= res.out_value;
      m_kind <= res.out_kind;
      m_last <= res.final_res;
    end
  end

endmodule

`default_nettype wire

[hdl/lsb_stego_stream_decoder_unit.sv]
// Top level of the LSB steganography stream decoder: configuration registers and stages.
// Depends on lsbsd_pkg, lsbsd_in_stage, lsbsd_decode and lsbsd_out_stage.
`default_nettype none

// Takes one image byte per transfer and sustains one byte per cycle unless m_axis_tready
// stalls the output. Each byte passes an input register, combinational decode logic
// (header skip count, bit gathering, field sequencing) and a result register.
// A result is produced only when a length, character or byte completes, or on a signature
// mismatch; tlast marks the result that ends the image. Bytes after the end are dropped
// until a byte arrives with tuser set. Registers: 0 first signature character, 1 second
// signature character, 2 header bytes to skip.
module lsb_stego_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // image_byte [7:0]
  input  wire logic        s_axis_tuser,   // start_req [0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // out_value [31:0]
  output      logic [2:0]  m_axis_tuser,   // out_kind [2:0]
  output      logic        m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  lsbsd_pkg::cfg_t    cfg;
  lsbsd_pkg::item_t   item;
  lsbsd_pkg::result_t res;
  logic               load_ok;
  logic               step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first  <= lsbsd_pkg::MAGIC_FIRST_RST;
      cfg.magic_second <= lsbsd_pkg::MAGIC_SECOND_RST;
      cfg.header_skip  <= lsbsd_pkg::HEADER_SKIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lsbsd_pkg::REG_MAGIC_FIRST:  cfg.magic_first  <= cfg_data;
        lsbsd_pkg::REG_MAGIC_SECOND: cfg.magic_second <= cfg_data;
        lsbsd_pkg::REG_HEADER_SKIP:  cfg.header_skip  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step = item.valid && load_ok;

  lsbsd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .s_start (s_axis_tuser),
    .consume (load_ok),
    .item    (item)
  );

  lsbsd_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  lsbsd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .res     (res),
    .load_ok (load_ok),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_kind  (m_axis_tuser),
    .m_last  (m_axis_tlast)
  );

  a_mismatch_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == lsbsd_pkg::KIND_MISMATCH)
      |-> m_axis_tlast && (m_axis_tdata == 32'd0))
    else $error("mismatch result not final or non-zero");

  a_ext_not_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ((m_axis_tuser == lsbsd_pkg::KIND_EXTLEN) ||
                      (m_axis_tuser == lsbsd_pkg::KIND_EXTCHR))
      |-> !m_axis_tlast)
    else $error("extension result marked final");

  a_zero_paylen_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == lsbsd_pkg::KIND_PAYLEN)
      |-> (m_axis_tlast == (m_axis_tdata == 32'd0)))
    else $error("payload length final flag wrong");

endmodule

`default_nettype wire
